>>> rtl/core/assert_macros.svh
// assertion helpers used by the averager unit
// each macro expects clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define WVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// trigger implies a condition in the next cycle
`define WVA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/wvva_pkg.sv
// ----------------------------------------------------------------------------
// wvva_pkg
// Constants and lookup tables of the wind vane vector averager.
// ----------------------------------------------------------------------------
package wvva_pkg;

  localparam int unsigned MaxSamplesDef  = 4095;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned NumSectors     = 16;
  localparam int unsigned AtanEntries    = 24;

  localparam int unsigned AdcW    = 12;
  localparam int unsigned SectorW = 4;
  localparam int unsigned SumW    = 28;
  localparam int unsigned CountW  = 12;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned CordW   = 32;
  localparam int unsigned TurnW   = 32;
  localparam int unsigned IterW   = 5;

  localparam logic [AdcW-1:0]   TolReset   = 12'd62;
  localparam logic [CountW-1:0] CountMax   = 12'd4095;
  localparam logic [AngleW-1:0] AngleScale = 16'd36000;
  localparam logic [TurnW-1:0]  HalfTurn   = 32'h8000_0000;

  // calibration adc code of each vane position
  function automatic logic [AdcW-1:0] vane_code(input logic [SectorW-1:0] k);
    logic [AdcW-1:0] c;
    unique case (k)
      4'd0:    c = 12'd510;
      4'd1:    c = 12'd1707;
      4'd2:    c = 12'd1491;
      4'd3:    c = 12'd3467;
      4'd4:    c = 12'd3376;
      4'd5:    c = 12'd3572;
      4'd6:    c = 12'd2789;
      4'd7:    c = 12'd3149;
      4'd8:    c = 12'd2237;
      4'd9:    c = 12'd2454;
      4'd10:   c = 12'd929;
      4'd11:   c = 12'd1022;
      4'd12:   c = 12'd153;
      4'd13:   c = 12'd410;
      4'd14:   c = 12'd276;
      default: c = 12'd724;
    endcase
    return c;
  endfunction

  // cosine of k * 22.5 degrees in q1.14, sine is entry k + 12
  function automatic logic signed [15:0] cos_q14(input logic [SectorW-1:0] k);
    logic signed [15:0] c;
    unique case (k)
      4'd0:    c = 16'sd16384;
      4'd1:    c = 16'sd15137;
      4'd2:    c = 16'sd11585;
      4'd3:    c = 16'sd6270;
      4'd4:    c = 16'sd0;
      4'd5:    c = -16'sd6270;
      4'd6:    c = -16'sd11585;
      4'd7:    c = -16'sd15137;
      4'd8:    c = -16'sd16384;
      4'd9:    c = -16'sd15137;
      4'd10:   c = -16'sd11585;
      4'd11:   c = -16'sd6270;
      4'd12:   c = 16'sd0;
      4'd13:   c = 16'sd6270;
      4'd14:   c = 16'sd11585;
      default: c = 16'sd15137;
    endcase
    return c;
  endfunction

  // atan(2^-i) as a binary fraction of a full turn
  function automatic logic [TurnW-1:0] atan_turn(input logic [IterW-1:0] i);
    logic [TurnW-1:0] a;
    unique case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/wind_vane_vector_average_unit.sv
// ----------------------------------------------------------------------------
// wind_vane_vector_average_unit
// Wind vane sample matcher with vector averaging and a cordic atan2 report.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o) takes one request item: a vane
//   adc sample (req_type 0) or a report request (req_type 1). Output channel
//   (out_valid_o / out_ready_i) returns exactly one result item per request.
//   cfg_we_i writes match_tolerance from cfg_wdata_i; write only while idle.
// Sequence
//   sample: one compare unit walks the code table from sector 0 up to the
//   matched sector (0..15), or through sector 15 with no match.
//   report: one shared add/shift cordic stage iterates, followed by a
//   multiply and a rounding cycle; a report on an empty or zero vector
//   skips the cordic.
// Throughput
//   one item in flight; in_ready_o is high only when the sequencer is idle.
// Reset
//   sums and count clear, tolerance returns to 62, no result pending.
// Stall
//   a finished result waits in the result registers (StDone) until the output
//   register frees; the next item is not accepted before then.
// ----------------------------------------------------------------------------
module wind_vane_vector_average_unit #(
  parameter int unsigned MaxSamples  = wvva_pkg::MaxSamplesDef,
  parameter int unsigned CordicSteps = wvva_pkg::CordicStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [wvva_pkg::AdcW-1:0]     cfg_wdata_i,
  // request items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_req_type_i,
  input  logic [wvva_pkg::AdcW-1:0]     in_adc_sample_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_sample_matched_o,
  output logic [wvva_pkg::SectorW-1:0]  out_sector_index_o,
  output logic                          out_mean_valid_o,
  output logic [wvva_pkg::AngleW-1:0]   out_mean_angle_o,
  output logic [wvva_pkg::CountW-1:0]   out_samples_used_o
);

  localparam logic [wvva_pkg::CountW-1:0] CountLimit =
    (MaxSamples < 4095) ? wvva_pkg::CountW'(MaxSamples) : wvva_pkg::CountMax;
  localparam int unsigned StepsUsed =
    (CordicSteps < wvva_pkg::AtanEntries) ? CordicSteps : wvva_pkg::AtanEntries;
  localparam logic [wvva_pkg::IterW-1:0] LastIter = wvva_pkg::IterW'(StepsUsed - 1);
  localparam logic [wvva_pkg::SectorW-1:0] LastSector =
    wvva_pkg::SectorW'(wvva_pkg::NumSectors - 1);
  localparam logic [wvva_pkg::SectorW-1:0] SinOffset = 4'd12;
  localparam int unsigned ProdW = wvva_pkg::TurnW + wvva_pkg::AngleW;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSearch = 6'b000010,
    StCordic = 6'b000100,
    StScale  = 6'b001000,
    StRound  = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [wvva_pkg::AdcW-1:0]          tol_q;
  logic signed [wvva_pkg::SumW-1:0]   sum_cos_q, sum_cos_d;
  logic signed [wvva_pkg::SumW-1:0]   sum_sin_q, sum_sin_d;
  logic [wvva_pkg::CountW-1:0]        sample_count_q, sample_count_d;

  logic [wvva_pkg::AdcW-1:0]          adc_q, adc_d;
  logic [wvva_pkg::SectorW-1:0]       sector_q, sector_d;
  logic [wvva_pkg::IterW-1:0]         iter_q, iter_d;
  logic signed [wvva_pkg::CordW-1:0]  x_q, x_d;
  logic signed [wvva_pkg::CordW-1:0]  y_q, y_d;
  logic [wvva_pkg::TurnW-1:0]         z_q, z_d;
  logic [ProdW-1:0]                   prod_q, prod_d;

  logic                               res_matched_q, res_matched_d;
  logic [wvva_pkg::SectorW-1:0]       res_sector_q, res_sector_d;
  logic                               res_mean_valid_q, res_mean_valid_d;
  logic [wvva_pkg::AngleW-1:0]        res_angle_q, res_angle_d;
  logic [wvva_pkg::CountW-1:0]        res_used_q, res_used_d;

  logic                               out_valid_q, out_valid_d;
  logic                               out_load;

  logic                               in_fire;
  logic signed [wvva_pkg::AdcW:0]     diff;
  logic [wvva_pkg::AdcW:0]            abs_dist;
  logic                               hit;
  logic signed [wvva_pkg::CordW-1:0]  sx, sy, dx, dy;
  logic [ProdW-1:0]                   rounded;
  logic [wvva_pkg::AngleW-1:0]        hund;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // shared compare unit: distance of the held sample to one table code
  always_comb begin
    diff     = $signed({1'b0, adc_q}) - $signed({1'b0, wvva_pkg::vane_code(sector_q)});
    abs_dist = diff[wvva_pkg::AdcW] ? 13'(-diff) : 13'(diff);
    hit      = (abs_dist <= {1'b0, tol_q});
  end

  // shared cordic stage: one micro-rotation toward y = 0
  always_comb begin
    dx = y_q >>> iter_q;
    dy = x_q >>> iter_q;
  end

  // sign-extended sums for the cordic start vector
  assign sx = wvva_pkg::CordW'(sum_cos_q);
  assign sy = wvva_pkg::CordW'(sum_sin_q);

  // rounding of the scaled angle to hundredths
  always_comb begin
    rounded = prod_q + ProdW'(wvva_pkg::HalfTurn);
    hund    = rounded[ProdW-1:wvva_pkg::TurnW];
  end

  // sequencer
  always_comb begin
    state_d          = state_q;
    sum_cos_d        = sum_cos_q;
    sum_sin_d        = sum_sin_q;
    sample_count_d   = sample_count_q;
    adc_d            = adc_q;
    sector_d         = sector_q;
    iter_d           = iter_q;
    x_d              = x_q;
    y_d              = y_q;
    z_d              = z_q;
    prod_d           = prod_q;
    res_matched_d    = res_matched_q;
    res_sector_d     = res_sector_q;
    res_mean_valid_d = res_mean_valid_q;
    res_angle_d      = res_angle_q;
    res_used_d       = res_used_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_matched_d    = 1'b0;
          res_sector_d     = '0;
          res_mean_valid_d = 1'b0;
          res_angle_d      = '0;
          res_used_d       = '0;
          if (!in_req_type_i) begin
            adc_d    = in_adc_sample_i;
            sector_d = '0;
            state_d  = StSearch;
          end else begin
            // report: take the sums, then clear the accumulator
            sum_cos_d      = '0;
            sum_sin_d      = '0;
            sample_count_d = '0;
            if (sample_count_q == '0) begin
              state_d = StDone;
            end else begin
              res_mean_valid_d = 1'b1;
              res_used_d       = sample_count_q;
              if (sum_cos_q == '0 && sum_sin_q == '0) begin
                state_d = StDone;
              end else begin
                x_d     = sum_cos_q[wvva_pkg::SumW-1] ? -sx : sx;
                y_d     = sum_cos_q[wvva_pkg::SumW-1] ? -sy : sy;
                z_d     = sum_cos_q[wvva_pkg::SumW-1] ? wvva_pkg::HalfTurn : '0;
                iter_d  = '0;
                state_d = StCordic;
              end
            end
          end
        end
      end
      StSearch: begin
        if (hit) begin
          if (sample_count_q < CountLimit) begin
            sum_cos_d      = sum_cos_q + wvva_pkg::SumW'(wvva_pkg::cos_q14(sector_q));
            sum_sin_d      = sum_sin_q +
                             wvva_pkg::SumW'(wvva_pkg::cos_q14(sector_q + SinOffset));
            sample_count_d = sample_count_q + 1'b1;
            res_matched_d  = 1'b1;
            res_sector_d   = sector_q;
          end
          state_d = StDone;
        end else if (sector_q == LastSector) begin
          state_d = StDone;
        end else begin
          sector_d = sector_q + 1'b1;
        end
      end
      StCordic: begin
        if (!y_q[wvva_pkg::CordW-1]) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + wvva_pkg::atan_turn(iter_q);
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - wvva_pkg::atan_turn(iter_q);
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == LastIter) begin
          state_d = StScale;
        end
      end
      StScale: begin
        prod_d  = {{wvva_pkg::AngleW{1'b0}}, z_q} *
                  {{wvva_pkg::TurnW{1'b0}}, wvva_pkg::AngleScale};
        state_d = StRound;
      end
      StRound: begin
        res_angle_d = (hund >= wvva_pkg::AngleScale) ? '0 : hund;
        state_d     = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      tol_q          <= wvva_pkg::TolReset;
      sum_cos_q      <= '0;
      sum_sin_q      <= '0;
      sample_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      sum_cos_q      <= sum_cos_d;
      sum_sin_q      <= sum_sin_d;
      sample_count_q <= sample_count_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    adc_q            <= adc_d;
    sector_q         <= sector_d;
    iter_q           <= iter_d;
    x_q              <= x_d;
    y_q              <= y_d;
    z_q              <= z_d;
    prod_q           <= prod_d;
    res_matched_q    <= res_matched_d;
    res_sector_q     <= res_sector_d;
    res_mean_valid_q <= res_mean_valid_d;
    res_angle_q      <= res_angle_d;
    res_used_q       <= res_used_d;
    if (out_load) begin
      out_sample_matched_o <= res_matched_q;
      out_sector_index_o   <= res_sector_q;
      out_mean_valid_o     <= res_mean_valid_q;
      out_mean_angle_o     <= res_angle_q;
      out_samples_used_o   <= res_used_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
`include "assert_macros.svh"

  `WVA_ASSERT(count_in_range_a, sample_count_q <= CountLimit, "sample count over limit")
  `WVA_ASSERT_NEXT(report_clears_a, in_fire && in_req_type_i,
    sample_count_q == '0 && sum_cos_q == '0 && sum_sin_q == '0, "report did not clear")
  `WVA_ASSERT(result_kind_a, !out_valid_o || !(out_sample_matched_o && out_mean_valid_o),
    "result is both a match and a mean")
  `WVA_ASSERT(angle_range_a, !out_valid_o || out_mean_angle_o < wvva_pkg::AngleScale,
    "mean angle out of range")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wind vane vector averager. Sample and report
// items are driven through the valid/ready input channel with random gaps,
// results are taken with random back-pressure, and every result is compared
// field by field against an in-bench model of the matcher, the vector sums
// and the cordic heading. Covers tolerance extremes, empty and zero reports.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CountLimit =
      (wvva_pkg::MaxSamplesDef < 4095) ? wvva_pkg::MaxSamplesDef : 4095;
  localparam int unsigned CordicIters =
      (wvva_pkg::CordicStepsDef < 24) ? wvva_pkg::CordicStepsDef : 24;
  localparam int unsigned ReportCycles = wvva_pkg::CordicStepsDef + 4;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_REPORT = 1'b1
  } vane_req_e;

  typedef struct packed {
    logic                          matched;
    logic [wvva_pkg::SectorW-1:0]  sector;
    logic                          mean_valid;
    logic [wvva_pkg::AngleW-1:0]   angle;
    logic [wvva_pkg::CountW-1:0]   used;
  } vane_result_t;

  // calibration codes, q1.14 cosines and cordic angles in turns
  localparam int VaneCodes [16] = '{
    510, 1707, 1491, 3467, 3376, 3572, 2789, 3149,
    2237, 2454, 929, 1022, 153, 410, 276, 724
  };
  localparam int CosTable [16] = '{
    16384, 15137, 11585, 6270, 0, -6270, -11585, -15137,
    -16384, -15137, -11585, -6270, 0, 6270, 11585, 15137
  };
  localparam longint AtanTurns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // tracks the vane sums and predicts each result item
  class vane_mean_tracker;
    int           tolerance;
    int           sum_cos;
    int           sum_sin;
    int unsigned  n_samples;
    vane_result_t pending_readings[$];
    int           mismatches;
    int           n_requests;
    int           n_matched;
    int           n_ignored;
    int           n_reports;
    int           n_means;

    function new();
      tolerance  = int'(wvva_pkg::TolReset);
      sum_cos    = 0;
      sum_sin    = 0;
      n_samples  = 0;
      mismatches = 0;
      n_requests = 0;
      n_matched  = 0;
      n_ignored  = 0;
      n_reports  = 0;
      n_means    = 0;
    endfunction

    // vectoring cordic, heading in hundredths of a degree
    function logic [15:0] mean_heading(longint x, longint y);
      logic [31:0]         z;
      longint              dx;
      longint              dy;
      logic [63:0]         h;
      int                  i;
      z = 32'd0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = wvva_pkg::HalfTurn;
      end
      for (i = 0; i < CordicIters; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + AtanTurns[i][31:0];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - AtanTurns[i][31:0];
        end
      end
      h = ({32'd0, z} * 64'd36000 + 64'h8000_0000) >> 32;
      if (h >= 64'd36000) h = 64'd0;
      return h[15:0];
    endfunction

    // accepted input item: update state, queue the expected result
    function void note_request(vane_req_e rt, logic [wvva_pkg::AdcW-1:0] adc);
      vane_result_t r;
      int           d;
      int           k;
      r = '0;
      n_requests++;
      if (rt == REQ_SAMPLE) begin
        for (k = 0; k < 16; k++) begin
          d = int'(adc) - VaneCodes[k];
          if (d < 0) d = -d;
          if (d <= tolerance) begin
            if (n_samples < CountLimit) begin
              sum_cos += CosTable[k];
              sum_sin += CosTable[(k + 12) % 16];
              n_samples++;
              r.matched = 1'b1;
              r.sector  = k[3:0];
              n_matched++;
            end else begin
              n_ignored++;
            end
            break;
          end
        end
      end else begin
        n_reports++;
        if (n_samples != 0) begin
          r.mean_valid = 1'b1;
          r.angle      = mean_heading(longint'(sum_cos), longint'(sum_sin));
          r.used       = n_samples[11:0];
          n_means++;
        end
        sum_cos   = 0;
        sum_sin   = 0;
        n_samples = 0;
      end
      pending_readings.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    // accepted result item against the oldest expectation
    task check_result(vane_result_t got);
      vane_result_t want;
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
        return;
      end
      want = pending_readings.pop_front();
      if (got.matched !== want.matched)
        report_mismatch("sample_matched", got.matched, want.matched);
      if (got.sector !== want.sector)
        report_mismatch("sector_index", got.sector, want.sector);
      if (got.mean_valid !== want.mean_valid)
        report_mismatch("mean_valid", got.mean_valid, want.mean_valid);
      if (got.angle !== want.angle)
        report_mismatch("mean_angle", got.angle, want.angle);
      if (got.used !== want.used)
        report_mismatch("samples_used", got.used, want.used);
    endtask
  endclass

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [wvva_pkg::AdcW-1:0]    cfg_wdata_i     = '0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_ready_o;
  logic                         in_req_type_i   = 1'b0;
  logic [wvva_pkg::AdcW-1:0]    in_adc_sample_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i     = 1'b0;
  logic                         out_sample_matched_o;
  logic [wvva_pkg::SectorW-1:0] out_sector_index_o;
  logic                         out_mean_valid_o;
  logic [wvva_pkg::AngleW-1:0]  out_mean_angle_o;
  logic [wvva_pkg::CountW-1:0]  out_samples_used_o;

  vane_mean_tracker tracker;
  bit               idle_mode = 1'b1;
  int               ready_hold = 0;
  int               n_tol_writes = 0;

  wind_vane_vector_average_unit u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_req_type_i        (in_req_type_i),
    .in_adc_sample_i      (in_adc_sample_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_sample_matched_o (out_sample_matched_o),
    .out_sector_index_o   (out_sector_index_o),
    .out_mean_valid_o     (out_mean_valid_o),
    .out_mean_angle_o     (out_mean_angle_o),
    .out_samples_used_o   (out_samples_used_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!idle_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: check accepted items, then choose next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_result('{out_sample_matched_o, out_sector_index_o, out_mean_valid_o,
                               out_mean_angle_o, out_samples_used_o});
      end
      if (ready_hold > 0) begin
        out_ready_i <= 1'b0;
        ready_hold--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
      end
    end
  end

  // drive one request item and wait for its handshake
  task automatic send_request(vane_req_e rt, logic [wvva_pkg::AdcW-1:0] adc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_req_type_i   <= rt;
    in_adc_sample_i <= adc;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(rt, adc);
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [wvva_pkg::AdcW-1:0] value);
    wait_for_results();
    repeat (ReportCycles) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.tolerance = int'(value);
    n_tol_writes++;
  endtask

  // a vane code near one of the calibration points
  function automatic logic [wvva_pkg::AdcW-1:0] near_code();
    int span;
    int v;
    span = (tracker.tolerance + 3 > 200) ? 200 : tracker.tolerance + 3;
    v = VaneCodes[$urandom_range(0, 15)] + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // bursts of samples closed by a report, with some stray items
  task automatic run_traffic(int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        len = $urandom_range(0, 12);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0)
            send_request(REQ_SAMPLE, 12'($urandom_range(0, 4095)));
          else
            send_request(REQ_SAMPLE, near_code());
          sent++;
        end
        if ($urandom_range(0, 5) == 0) wait_for_results();
        send_request(REQ_REPORT, 12'($urandom_range(0, 4095)));
        sent++;
      end else if (r < 95) begin
        send_request(REQ_SAMPLE, 12'($urandom_range(0, 4095)));
        sent++;
      end else begin
        send_request(REQ_REPORT, 12'($urandom_range(0, 4095)));
        sent++;
      end
    end
  endtask

  // run limit
  initial begin
    #15_000_000;
    $display("timeout with %0d results outstanding", tracker.pending_readings.size());
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items at the reset tolerance
    send_request(REQ_REPORT, 12'd0);
    send_request(REQ_SAMPLE, 12'd510);
    send_request(REQ_REPORT, 12'hFFF);
    send_request(REQ_SAMPLE, 12'd4095);
    send_request(REQ_SAMPLE, 12'd0);
    send_request(REQ_SAMPLE, 12'd572);
    send_request(REQ_SAMPLE, 12'd573);
    send_request(REQ_REPORT, 12'd0);
    // opposite sectors cancel: count without a direction
    send_request(REQ_SAMPLE, 12'd510);
    send_request(REQ_SAMPLE, 12'd2237);
    send_request(REQ_REPORT, 12'd0);
    send_request(REQ_SAMPLE, 12'd1707);
    send_request(REQ_REPORT, 12'd0);
    // negative cosine sum with both sine signs, then a positive cosine sum
    send_request(REQ_SAMPLE, 12'd3572);
    send_request(REQ_SAMPLE, 12'd3149);
    send_request(REQ_REPORT, 12'd0);
    send_request(REQ_SAMPLE, 12'd153);
    send_request(REQ_SAMPLE, 12'd2789);
    send_request(REQ_REPORT, 12'd0);
    send_request(REQ_SAMPLE, 12'd276);
    send_request(REQ_SAMPLE, 12'd724);
    send_request(REQ_REPORT, 12'd0);

    // random traffic over several tolerance settings
    write_tolerance(12'd0);
    run_traffic(100);
    idle_mode = 1'b0;
    write_tolerance(12'd4095);
    run_traffic(50);
    idle_mode = 1'b1;
    write_tolerance(12'($urandom_range(1, 200)));
    run_traffic(80);
    write_tolerance(12'($urandom_range(0, 4095)));
    run_traffic(70);
    write_tolerance(12'd62);
    run_traffic(150);
    run_traffic(30);

    wait_for_results();
    repeat (ReportCycles + 10) @(posedge clk_i);
    if (tracker.pending_readings.size() != 0)
      tracker.report_mismatch("results never returned", 0,
                              tracker.pending_readings.size());
    $display("run covered %0d requests: %0d samples accumulated, %0d dropped at full count",
             tracker.n_requests, tracker.n_matched, tracker.n_ignored);
    $display("%0d reports (%0d with a mean) over %0d tolerance settings",
             tracker.n_reports, tracker.n_means, n_tol_writes + 1);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/wvva_pkg.sv
rtl/core/wind_vane_vector_average_unit.sv
test/tb_top.sv
